@@ rtl/bitmap_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_macros.svh
// Assertion macros shared by the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("bitmap_block_allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("bitmap_block_allocator: next-cycle check failed");

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Widths, register indexes and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 17;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 64;
    localparam int PADDR_W  = 5;
    localparam int WORD_SH  = 5;
    localparam int WORD_W   = 1 << WORD_SH;
    localparam int STEP_W   = 6;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Request modes
    localparam logic MODE_ALLOCATE = 1'b0;
    localparam logic MODE_FREE     = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_ALLOCATED = 2'd0;
    localparam status_t ST_EXHAUSTED = 2'd1;
    localparam status_t ST_FREED     = 2'd2;
    localparam status_t ST_IGNORED   = 2'd3;

endpackage

@@ rtl/bitmap_block_allocator.sv @@
// Allocate: first-fit scan, reading then checking each map word (32 blocks a word),
//   then index*size and base+product; exhausted when no block below the count is free.
// Free: offset = address - base, 48-step bit-serial divide by the size; ignored
//   past the count, for a zero address or for one below base.
// One transaction at a time; the next is taken once the result registers,
//   even while it waits. Reset (rst_n, async low) clears the whole map first.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator of fixed-size blocks over a one-bit-per-block map.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB-style configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [bba_pkg::DATA_W-1:0]   pwdata,
    output logic [bba_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [bba_pkg::ADDR_W-1:0]   free_address,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bba_pkg::ADDR_W-1:0]   block_address,
    output logic [bba_pkg::STATUS_W-1:0] status
);
    import bba_pkg::*;

    // Map geometry: the map is a RAM of 32-bit words.
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int FULL_W    = WADDR_W + 1 + WORD_SH;
    localparam int PROD_W    = IDX_W + SIZE_W;

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;   // post-reset map clearing pass
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;   // issue read of next map word
    localparam logic [3:0] S_SCHK  = 4'd3;   // look for a free bit in it
    localparam logic [3:0] S_AMUL  = 4'd4;   // index * block size
    localparam logic [3:0] S_AADD  = 4'd5;   // base + product
    localparam logic [3:0] S_FSUB  = 4'd6;   // range check, offset = addr - base
    localparam logic [3:0] S_FDIV  = 4'd7;   // one quotient bit per cycle
    localparam logic [3:0] S_FCHK  = 4'd8;   // index range check, read word
    localparam logic [3:0] S_FWR   = 4'd9;   // clear the bit
    localparam logic [3:0] S_DONE  = 4'd10;  // hand result to output register

    // Configuration registers
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    // Sequencer and datapath registers
    logic [3:0]         state_reg,     state_next;
    logic [WADDR_W:0]   wcnt_reg,      wcnt_next;
    logic [WADDR_W-1:0] clr_ptr_reg,   clr_ptr_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic [PROD_W-1:0]  prod_reg,      prod_next;
    logic [ADDR_W-1:0]  quo_reg,       quo_next;
    logic [SIZE_W-1:0]  rem_reg,       rem_next;
    logic [STEP_W-1:0]  step_reg,      step_next;
    logic [ADDR_W-1:0]  res_addr_reg,  res_addr_next;
    status_t            res_stat_reg,  res_stat_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg,  out_addr_next;
    status_t            out_stat_reg,  out_stat_next;

    // Usage map RAM, one write and one registered read port
    logic [WORD_W-1:0]  map_mem [NUM_WORDS];
    logic [WORD_W-1:0]  rdata_reg;
    logic               mem_re;
    logic [WADDR_W-1:0] mem_raddr;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    // Effective configuration
    logic [SIZE_W-1:0]  size_eff;
    logic [CMP_W-1:0]   cnt_cmp;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W:0]     nwords;
    logic [CNT_W:0]     wcnt_ext;
    logic [CNT_W:0]     bits_left;
    logic [WORD_W-1:0]  valid_mask;
    logic [WORD_W-1:0]  free_bits;
    logic               hit;
    logic [WORD_SH-1:0] hit_pos;
    logic [FULL_W-1:0]  idx_full;

    // Divider step
    logic [SIZE_W:0]    div_shift;
    logic               div_ge;
    logic [SIZE_W:0]    div_diff;

    logic               cfg_wr;
    logic               in_xact;

    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign in_xact = in_valid && in_ready;

    assign out_valid     = out_valid_reg;
    assign block_address = out_addr_reg;
    assign status        = out_stat_reg;

    always_comb
    begin
        case (paddr[4:3])
            REG_BASE:  prdata = DATA_W'(base_reg);
            REG_SIZE:  prdata = DATA_W'(size_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    // Size zero acts as one; count saturates at the map depth.
    assign size_eff = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign cnt_cmp  = (CMP_W'(count_reg) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                                : CMP_W'(count_reg);
    assign cnt_eff  = CNT_W'(cnt_cmp);

    // Words to scan, and which bits of the current word lie below the count
    assign nwords    = ((CNT_W + 1)'(cnt_eff) + (CNT_W + 1)'(WORD_W - 1)) >> WORD_SH;
    assign wcnt_ext  = (CNT_W + 1)'(wcnt_reg);
    assign bits_left = (CNT_W + 1)'(cnt_eff) - (wcnt_ext << WORD_SH);

    always_comb
    begin
        if (bits_left >= (CNT_W + 1)'(WORD_W))
            valid_mask = '1;
        else
            valid_mask = (WORD_W'(1) << bits_left[WORD_SH-1:0]) - WORD_W'(1);
    end

    // Lowest free bit of the word just read
    always_comb
    begin
        free_bits = ~rdata_reg & valid_mask;
        hit       = |free_bits;
        hit_pos   = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (free_bits[b])
                hit_pos = WORD_SH'(b);
        end
    end

    assign idx_full = {wcnt_reg, hit_pos};

    // Restoring division: shift in next offset bit, subtract if it fits
    assign div_shift = {rem_reg, quo_reg[ADDR_W-1]};
    assign div_ge    = (div_shift >= {1'b0, size_eff});
    assign div_diff  = div_shift - {1'b0, size_eff};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wcnt_next      = wcnt_reg;
        clr_ptr_next   = clr_ptr_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;
        mem_re         = 1'b0;
        mem_raddr      = wcnt_reg[WADDR_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = wcnt_reg[WADDR_W-1:0];
        mem_wdata      = rdata_reg | (WORD_W'(1) << hit_pos);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_ptr_reg;
                mem_wdata = '0;
                if (clr_ptr_reg == WADDR_W'(NUM_WORDS - 1))
                    state_next = S_IDLE;
                else
                    clr_ptr_next = clr_ptr_reg + WADDR_W'(1);
            end
            S_IDLE:
            begin
                if (in_xact)
                begin
                    wcnt_next = '0;
                    quo_next  = free_address;
                    state_next = (mode == MODE_FREE) ? S_FSUB : S_SRD;
                end
            end
            S_SRD:
            begin
                if (wcnt_ext == nwords)
                begin
                    res_addr_next = '0;
                    res_stat_next = ST_EXHAUSTED;
                    state_next    = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (hit)
                begin
                    mem_we     = 1'b1;
                    idx_next   = idx_full[IDX_W-1:0];
                    state_next = S_AMUL;
                end
                else
                begin
                    wcnt_next  = wcnt_reg + (WADDR_W + 1)'(1);
                    state_next = S_SRD;
                end
            end
            S_AMUL:
            begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(size_eff);
                state_next = S_AADD;
            end
            S_AADD:
            begin
                res_addr_next = base_reg + ADDR_W'(prod_reg);
                res_stat_next = ST_ALLOCATED;
                state_next    = S_DONE;
            end
            S_FSUB:
            begin
                res_addr_next = '0;
                if (quo_reg == '0 || quo_reg < base_reg)
                begin
                    res_stat_next = ST_IGNORED;
                    state_next    = S_DONE;
                end
                else
                begin
                    quo_next   = quo_reg - base_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                rem_next  = div_ge ? div_diff[SIZE_W-1:0] : div_shift[SIZE_W-1:0];
                quo_next  = {quo_reg[ADDR_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ADDR_W - 1))
                    state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (quo_reg >= ADDR_W'(cnt_eff))
                begin
                    res_stat_next = ST_IGNORED;
                    state_next    = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = quo_reg[WADDR_W+WORD_SH-1:WORD_SH];
                    state_next = S_FWR;
                end
            end
            S_FWR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = quo_reg[WADDR_W+WORD_SH-1:WORD_SH];
                mem_wdata     = rdata_reg & ~(WORD_W'(1) << quo_reg[WORD_SH-1:0]);
                res_stat_next = ST_FREED;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // wait here only while the previous result is still held
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            size_reg      <= SIZE_W'(64);
            count_reg     <= COUNT_W'(1024);
            state_reg     <= S_CLEAR;
            clr_ptr_reg   <= '0;
            wcnt_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[4:3])
                    REG_BASE:  base_reg  <= pwdata[ADDR_W-1:0];
                    REG_SIZE:  size_reg  <= pwdata[SIZE_W-1:0];
                    REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                    default:   ;
                endcase
            end
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            wcnt_reg      <= wcnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    // Map RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= map_mem[mem_raddr];
    end

endmodule

@@ rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bba_pkg::ADDR_W-1:0]   block_address,
    input logic [bba_pkg::STATUS_W-1:0] status
);
    import bba_pkg::*;

    // stalled result holds
    `BBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(block_address) && $stable(status))

    // only a successful allocation carries an address
    `BBA_ASSERT_NOW(a_addr_zero, clk, rst_n, out_valid && status != ST_ALLOCATED,
        block_address == '0)

    // one transaction in flight: busy right after a request is taken
    `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
